>>> src/amm_pkg.sv
package amm_pkg;

   // Fixed field widths of the sample and result transactions.
   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 48;
   localparam int IDX_OUT_W  = 16;
   localparam int CNT_OUT_W  = 17;
   localparam int MEAN_W     = 32;

   // Result tdata: all six fields packed, padded with zeros to whole bytes.
   localparam int RSP_FIELDS_W = SAMPLE_W + IDX_OUT_W + SAMPLE_W + IDX_OUT_W
                                 + MEAN_W + CNT_OUT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // The divider retires one quotient bit per cycle over the whole sum.
   localparam int DIV_STEPS = SUM_W;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

>>> src/amm_front.sv
module amm_front #(
   parameter int MAX_ELEMENTS = 65536,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int REC_W = 2 * amm_pkg::SAMPLE_W + 2 * IDX_W + amm_pkg::SUM_W + CNT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic             req_tlast,
   input  logic             queue_full,
   output logic             queue_push,
   output logic [REC_W-1:0] queue_data
);

   logic signed [amm_pkg::SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in, sample_val;
   logic [IDX_W-1:0]                    min_idx_ff, min_idx_in, max_idx_ff, max_idx_in;
   logic [IDX_W-1:0]                    cur_idx;
   logic [amm_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic                                accept, first, take_min, take_max, close_set;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign sample_val = signed'(req_tdata[amm_pkg::SAMPLE_W-1:0]);
   assign first      = (cnt_ff == '0);
   assign cur_idx    = cnt_ff[IDX_W-1:0];

   always_comb begin
      // Strict compares keep the earliest position on ties.
      take_min   = first || (sample_val < min_ff);
      take_max   = first || (sample_val > max_ff);
      min_in     = take_min ? sample_val : min_ff;
      min_idx_in = take_min ? cur_idx : min_idx_ff;
      max_in     = take_max ? sample_val : max_ff;
      max_idx_in = take_max ? cur_idx : max_idx_ff;
      sum_in     = sum_ff + amm_pkg::SUM_W'(sample_val);
      cnt_in     = cnt_ff + 1'b1;
      // A full set closes even without its end mark.
      close_set  = req_tlast || (cnt_in == CNT_W'(MAX_ELEMENTS));
   end

   assign queue_push = accept && close_set;
   assign queue_data = {cnt_in, sum_in, max_idx_in, max_in, min_idx_in, min_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         sum_ff <= close_set ? '0 : sum_in;
         cnt_ff <= close_set ? '0 : cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_ff     <= min_in;
         min_idx_ff <= min_idx_in;
         max_ff     <= max_in;
         max_idx_ff <= max_idx_in;
      end
   end

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (cnt_ff == '0))
      else $error("set did not restart after its end mark");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ELEMENTS - 1))
      else $error("element count ran past the set size limit");

endmodule

>>> src/amm_fifo.sv
module amm_fifo #(
   parameter int REC_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [REC_W-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [REC_W-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [REC_W-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("set record pushed into a full queue");

endmodule

>>> src/amm_back.sv
module amm_back #(
   parameter int MAX_ELEMENTS = 65536,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int REC_W = 2 * amm_pkg::SAMPLE_W + 2 * IDX_W + amm_pkg::SUM_W + CNT_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  logic [REC_W-1:0]                 queue_data,
   output logic                             queue_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [amm_pkg::SAMPLE_W-1:0]     out_min_value,
   output logic [amm_pkg::IDX_OUT_W-1:0]    out_min_index,
   output logic [amm_pkg::SAMPLE_W-1:0]     out_max_value,
   output logic [amm_pkg::IDX_OUT_W-1:0]    out_max_index,
   output logic [amm_pkg::MEAN_W-1:0]       out_mean_value,
   output logic [amm_pkg::CNT_OUT_W-1:0]    out_element_count
);

   localparam int SW     = amm_pkg::SUM_W;
   localparam int STEP_W = $clog2(amm_pkg::DIV_STEPS);
   localparam int MAX_LO = 0;
   localparam int MAX_IX = amm_pkg::SAMPLE_W;
   localparam int MAX_HI = amm_pkg::SAMPLE_W + IDX_W;
   localparam int MAXI_L = 2 * amm_pkg::SAMPLE_W + IDX_W;
   localparam int SUM_L  = 2 * amm_pkg::SAMPLE_W + 2 * IDX_W;
   localparam int CNT_L  = SUM_L + SW;

   amm_pkg::div_state_type state_ff, state_in;

   logic [REC_W-1:0]   rec_ff;
   logic [SW-1:0]      quo_ff, sum_rec, mag, quo_step, quo_signed;
   logic [CNT_W-1:0]   rem_ff, div_ff, rem_step;
   logic [CNT_W:0]     rem_shift, diff;
   logic [STEP_W-1:0]  step_ff;
   logic               neg_ff, fits, load_out, out_valid_ff;
   logic [IDX_W+amm_pkg::IDX_OUT_W-1:0]  min_idx_wide, max_idx_wide;
   logic [CNT_W+amm_pkg::CNT_OUT_W-1:0]  cnt_wide;

   // Restoring division on the magnitude of the sum, one quotient bit a cycle.
   always_comb begin
      sum_rec   = queue_data[SUM_L +: SW];
      mag       = sum_rec[SW-1] ? (~sum_rec + 1'b1) : sum_rec;
      rem_shift = {rem_ff, quo_ff[SW-1]};
      diff      = rem_shift - {1'b0, div_ff};
      fits      = !diff[CNT_W];
      rem_step  = fits ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo_step  = {quo_ff[SW-2:0], fits};
      quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

   always_comb begin
      state_in  = state_ff;
      queue_pop = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         amm_pkg::DIV_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               state_in  = amm_pkg::DIV_RUN;
            end
         end
         amm_pkg::DIV_RUN: begin
            if (step_ff == STEP_W'(amm_pkg::DIV_STEPS - 1)) begin
               state_in = amm_pkg::DIV_DONE;
            end
         end
         amm_pkg::DIV_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = amm_pkg::DIV_IDLE;
            end
         end
         default: state_in = amm_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amm_pkg::DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rec_ff  <= queue_data;
         neg_ff  <= sum_rec[SW-1];
         quo_ff  <= mag;
         rem_ff  <= '0;
         div_ff  <= queue_data[CNT_L +: CNT_W];
         step_ff <= '0;
      end else if (state_ff == amm_pkg::DIV_RUN) begin
         quo_ff  <= quo_step;
         rem_ff  <= rem_step;
         step_ff <= step_ff + 1'b1;
      end
   end

   assign min_idx_wide = {{amm_pkg::IDX_OUT_W{1'b0}}, rec_ff[MAX_IX +: IDX_W]};
   assign max_idx_wide = {{amm_pkg::IDX_OUT_W{1'b0}}, rec_ff[MAXI_L +: IDX_W]};
   assign cnt_wide     = {{amm_pkg::CNT_OUT_W{1'b0}}, div_ff};

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_min_value     <= rec_ff[MAX_LO +: amm_pkg::SAMPLE_W];
         out_min_index     <= min_idx_wide[amm_pkg::IDX_OUT_W-1:0];
         out_max_value     <= rec_ff[MAX_HI +: amm_pkg::SAMPLE_W];
         out_max_index     <= max_idx_wide[amm_pkg::IDX_OUT_W-1:0];
         out_mean_value    <= quo_signed[amm_pkg::MEAN_W-1:0];
         out_element_count <= cnt_wide[amm_pkg::CNT_OUT_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amm_pkg::DIV_RUN) |-> (rem_ff < div_ff))
      else $error("partial remainder not below the divisor");

endmodule

>>> src/array_min_max_mean_top.sv
// Running minimum, maximum and mean over sets of signed 32-bit samples. Each
// req transaction carries one sample in req_tdata and marks the final sample
// of a set with req_tlast; a set also closes by itself once it holds
// MAX_ELEMENTS samples. For every set one rsp transaction returns the minimum
// and maximum with the index (from 0) of their first occurrence, the mean
// (sum divided by count, truncated toward zero) and the element count. The
// front end takes one sample per cycle: it updates the running minimum,
// maximum, 48-bit sum and count on each accepted sample and, on the closing
// sample, writes a set record into a four-entry queue. The back end takes
// records from that queue and divides the sum by the count with a restoring
// divider that produces one quotient bit per cycle; each set passes through
// a load step, 48 divide steps and an output step in the back end. Samples
// stall only when four finished sets are waiting in the queue; the result
// sits in an output register, so a new division proceeds while the previous
// result waits for rsp_tready.
module array_min_max_mean_top #(
   parameter int MAX_ELEMENTS = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // [31:0] sample
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] min_value, [47:32] min_index, [79:48] max_value,
   // [95:80] max_index, [127:96] mean_value, [144:128] element_count, rest zero
   output logic [amm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int REC_W = 2 * amm_pkg::SAMPLE_W + 2 * IDX_W + amm_pkg::SUM_W + CNT_W;

   logic                             queue_push, queue_pop, queue_full, queue_empty;
   logic [REC_W-1:0]                 push_data, pop_data;
   logic [amm_pkg::SAMPLE_W-1:0]     min_value, max_value;
   logic [amm_pkg::IDX_OUT_W-1:0]    min_index, max_index;
   logic [amm_pkg::MEAN_W-1:0]       mean_value;
   logic [amm_pkg::CNT_OUT_W-1:0]    element_count;

   // Front end: running statistics, one sample per cycle while the queue has room.
   amm_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   // Finished set records waiting for the divider.
   amm_fifo #(
      .REC_W(REC_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // Back end: mean division and the result register.
   amm_back #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_data        (pop_data),
      .queue_pop         (queue_pop),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .out_min_value     (min_value),
      .out_min_index     (min_index),
      .out_max_value     (max_value),
      .out_max_index     (max_index),
      .out_mean_value    (mean_value),
      .out_element_count (element_count)
   );

   // Pack the result fields from the lowest bit up and pad to whole bytes.
   assign rsp_tdata = {{(amm_pkg::RSP_DATA_W - amm_pkg::RSP_FIELDS_W){1'b0}},
                       element_count, mean_value, max_index, max_value,
                       min_index, min_value};

endmodule
